// ----- sv/sat_pkg.sv -----
// Shared types, opcodes and slot update functions for the sprite animation slot table.
package sat_pkg;

  // Operation codes
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_PLAY   = 3'd1;
  localparam logic [2:0] OP_ONCE   = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_SETFRM = 3'd4;
  localparam logic [2:0] OP_ADV    = 3'd5;
  localparam logic [2:0] OP_TICK   = 3'd6;
  localparam logic [2:0] OP_READ   = 3'd7;

  localparam int SLOTS_DEF = 64;

  // One slot record as stored in the table
  typedef struct packed {
    logic        playing;
    logic        once;
    logic [15:0] frame;
    logic [9:0]  total;
    logic [15:0] timer;
    logic [14:0] reload;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  // Frame increment with 16-bit wrap; clear at the total. Bit 16 flags the wrap.
  function automatic logic [16:0] frame_bump(input logic [15:0] frame,
                                             input logic [9:0] total);
    logic [15:0] f;
    logic        wrap;
    f    = frame + 16'd1;
    wrap = ($signed(f) >= $signed({7'd0, total}));
    if (wrap) begin
      f = 16'd0;
    end
    return {wrap, f};
  endfunction

  // Apply one addressed (non-tick) operation to a slot record
  function automatic slot_rec_t apply_op(input slot_rec_t r, input logic [2:0] op,
                                         input logic [9:0] total_in,
                                         input logic [14:0] reload_in,
                                         input logic [15:0] frame_in,
                                         input logic [15:0] timer_in);
    slot_rec_t   n;
    logic [15:0] f;
    logic [16:0] b;
    n = r;
    case (op)
      OP_LOAD: begin
        n.frame  = frame_in;
        n.total  = total_in;
        n.timer  = timer_in;
        n.reload = reload_in;
      end
      OP_PLAY, OP_ONCE: begin
        if (r.total > 10'd1) begin
          n.playing = 1'b1;
        end
        if (op == OP_ONCE) begin
          n.once = 1'b1;
        end
      end
      OP_STOP: begin
        n.playing = 1'b0;
      end
      OP_SETFRM: begin
        f = frame_in[15] ? 16'd0 : frame_in;
        if (f >= {6'd0, r.total}) begin
          f = {6'd0, r.total} - 16'd1;
        end
        n.frame = f;
      end
      OP_ADV: begin
        b       = frame_bump(r.frame, r.total);
        n.frame = b[15:0];
      end
      default: begin
        n = r;
      end
    endcase
    return n;
  endfunction

endpackage

// ----- sv/sat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/sprite_animation_slot_table.sv -----
// Sprite animation slot table: slot records in one RAM, updated by a shared slot unit.
//
//   channel | signals                                                   | direction
//   --------+-----------------------------------------------------------+----------
//   input   | in_valid, in_ready, opcode, slot, frame_total,            | in
//           | reload_delay, frame_value, timer_value                    |
//   output  | out_valid, out_ready, frame, playing, play_once,          | out
//           | removed, stopped_count                                    |
//
// Addressed operations pass through S_EXEC (RAM update, result staged) and S_PUT (output
// register loaded); the next word is taken after that, back in S_IDLE.
// Tick sweeps the slot RAM through the one update unit, one slot a cycle; the result
// then goes out through S_PUT.
// After reset a clearing pass writes zero to every slot, with in_ready low.
// in_ready is high only while no operation is in flight; a finished result waits in a
// staging register until the output register is free, then the next word is taken.
module sprite_animation_slot_table
  import sat_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [5:0]         slot,
  input  logic [9:0]         frame_total,
  input  logic [14:0]        reload_delay,
  input  logic signed [15:0] frame_value,
  input  logic signed [15:0] timer_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] frame,
  output logic               playing,
  output logic               play_once,
  output logic               removed,
  output logic [6:0]         stopped_count
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW  = (IW > 6) ? IW : 6;
  localparam logic [IW:0] LAST = (IW + 1)'(SLOTS - 1);
  localparam logic [IW:0] ENDC = (IW + 1)'(SLOTS);
  localparam logic [IW:0] IDX_ONE = (IW + 1)'(1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;

  logic [2:0]   state;
  logic [IW:0]  sweep_idx;
  logic         wb_vld;
  logic [IW-1:0] wb_idx;

  // Latched operation
  logic [2:0]   op;
  logic [IW-1:0] op_idx;
  logic         op_ok;
  logic [9:0]   op_total;
  logic [14:0]  op_reload;
  logic [15:0]  op_frame;
  logic [15:0]  op_timer;

  // Result staging
  logic [15:0]  res_frame;
  logic         res_playing;
  logic         res_once;
  logic         res_removed;
  logic [6:0]   stop_cnt;

  // RAM ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata;

  slot_rec_t    rd_rec;
  slot_rec_t    op_rec;
  slot_rec_t    tk_rec;
  logic         tk_stop;
  logic [16:0]  tk_bump;
  logic [SW-1:0] slot_wide;
  logic          in_ok;
  logic          accept;
  logic          put_go;

  assign rd_rec    = slot_rec_t'(ram_rdata);
  assign slot_wide = SW'(slot);
  assign in_ok     = (32'(slot) < 32'(SLOTS));
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign put_go    = (state == S_PUT) && (!out_valid || out_ready);

  sat_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Addressed operation update
  assign op_rec = apply_op(rd_rec, op, op_total, op_reload, op_frame, op_timer);

  // Tick update of one playing slot: count down by 2, or advance, wrap, reload and end a play-once run
  always_comb begin
    tk_rec  = rd_rec;
    tk_stop = 1'b0;
    tk_bump = frame_bump(rd_rec.frame, rd_rec.total);
    if (rd_rec.playing) begin
      if ($signed(rd_rec.timer) < 16'sd2) begin
        tk_rec.frame = tk_bump[15:0];
        if (tk_bump[16] && rd_rec.once) begin
          tk_rec.once    = 1'b0;
          tk_rec.playing = 1'b0;
          tk_stop        = 1'b1;
        end
        tk_rec.timer = {1'b0, rd_rec.reload};
      end else begin
        tk_rec.timer = rd_rec.timer - 16'd2;
      end
    end
  end

  // Select RAM addresses and write data by state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_idx[IW-1:0];
      end
      S_IDLE: begin
        ram_raddr = slot_wide[IW-1:0];
      end
      S_EXEC: begin
        ram_we    = op_ok && (op != OP_READ);
        ram_waddr = op_idx;
        ram_wdata = REC_W'(op_rec);
      end
      S_TICK: begin
        ram_raddr = sweep_idx[IW-1:0];
        ram_we    = wb_vld;
        ram_waddr = wb_idx;
        ram_wdata = REC_W'(tk_rec);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep_idx <= '0;
      wb_vld    <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          sweep_idx <= sweep_idx + IDX_ONE;
          if (sweep_idx == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          sweep_idx <= '0;
          wb_vld    <= 1'b0;
          if (accept) begin
            state <= (opcode == OP_TICK) ? S_TICK : S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_PUT;
        end
        S_TICK: begin
          if (sweep_idx != ENDC) begin
            sweep_idx <= sweep_idx + IDX_ONE;
            wb_vld    <= 1'b1;
          end else begin
            wb_vld <= 1'b0;
            if (!wb_vld) begin
              state <= S_PUT;
            end
          end
        end
        S_PUT: begin
          if (put_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Track the slot whose read data arrives next cycle
  always_ff @(posedge clk) begin
    wb_idx <= sweep_idx[IW-1:0];
  end

  // Capture the operation word on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= opcode;
      op_idx    <= slot_wide[IW-1:0];
      op_ok     <= in_ok;
      op_total  <= frame_total;
      op_reload <= reload_delay;
      op_frame  <= frame_value;
      op_timer  <= timer_value;
    end
  end

  // Build the result: addressed update, or the addressed slot seen during the sweep and the count of slots it stopped
  always_ff @(posedge clk) begin
    if (accept) begin
      res_frame   <= '0;
      res_playing <= 1'b0;
      res_once    <= 1'b0;
      res_removed <= 1'b0;
      stop_cnt    <= '0;
    end else if (state == S_EXEC) begin
      res_frame   <= op_rec.frame;
      res_playing <= op_rec.playing;
      res_once    <= op_rec.once;
      res_removed <= op_ok && (op == OP_STOP) && rd_rec.playing;
    end else if ((state == S_TICK) && wb_vld) begin
      if (wb_idx == op_idx) begin
        res_frame   <= tk_rec.frame;
        res_playing <= tk_rec.playing;
        res_once    <= tk_rec.once;
      end
      if (tk_stop && (stop_cnt != 7'd127)) begin
        stop_cnt <= stop_cnt + 7'd1;
      end
    end
  end

  // Output register: load from staging when free, drop on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_go) begin
      frame         <= op_ok ? res_frame : 16'd0;
      playing       <= op_ok && res_playing;
      play_once     <= op_ok && res_once;
      removed       <= res_removed;
      stopped_count <= stop_cnt;
    end
  end

  // A stop that removed a slot never reports it playing, and never counts wraps
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && removed) |-> (!playing && (stopped_count == 7'd0)))
    else $error("removed result inconsistent");

  // Sweep write-back only happens inside a tick
  assert property (@(posedge clk) disable iff (rst)
    wb_vld |-> (state == S_TICK))
    else $error("write-back outside tick sweep");

  // A new result is loaded only after the previous one left
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !put_go)
    else $error("result overwritten while stalled");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the sprite animation slot table: directed table, then random words.
`timescale 1ns / 1ps

module tb;
  import sat_pkg::*;

  localparam int NSLOT      = 64;
  localparam int RAND_WORDS = 1200;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 100;

  // Result of one operation, as seen on the output channel
  typedef struct packed {
    logic signed [15:0] frame;
    logic               playing;
    logic               once;
    logic               removed;
    logic [6:0]         stopped;
  } slot_view_t;

  // One row of the directed table
  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [9:0]  total;
    logic [14:0] reload;
    logic [15:0] fval;
    logic [15:0] tval;
    logic        fixed_on;
    slot_view_t  fixed;
  } drill_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         opcode;
  logic [5:0]         slot;
  logic [9:0]         frame_total;
  logic [14:0]        reload_delay;
  logic signed [15:0] frame_value;
  logic signed [15:0] timer_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] frame;
  logic               playing;
  logic               play_once;
  logic               removed;
  logic [6:0]         stopped_count;

  sprite_animation_slot_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .slot          (slot),
    .frame_total   (frame_total),
    .reload_delay  (reload_delay),
    .frame_value   (frame_value),
    .timer_value   (timer_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame         (frame),
    .playing       (playing),
    .play_once     (play_once),
    .removed       (removed),
    .stopped_count (stopped_count)
  );

  // Shadow copy of the slot table
  logic        anim_playing [NSLOT];
  logic        anim_once    [NSLOT];
  logic [15:0] anim_frame   [NSLOT];
  logic [9:0]  anim_total   [NSLOT];
  logic [15:0] anim_timer   [NSLOT];
  logic [14:0] anim_reload  [NSLOT];

  slot_view_t view_q[$];
  drill_row_t drill_q[$];
  slot_view_t want;
  int         fails;
  int         op_seen [8];
  int         self_stops;
  int         removals;
  int         idle_cycles;
  int         stall_mode;
  int         stall_left;
  int         stall_tick;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Step a slot's frame with 16-bit wrap, clear at the total; report the wrap
  function automatic bit bump_anim_frame(input int s);
    logic [15:0] f;
    f = anim_frame[s] + 16'd1;
    if ($signed(f) >= $signed({6'd0, anim_total[s]})) begin
      anim_frame[s] = 16'd0;
      return 1'b1;
    end
    anim_frame[s] = f;
    return 1'b0;
  endfunction

  // Apply one word to the shadow table and return the view it should produce
  function automatic slot_view_t predict_view(input logic [2:0] op, input logic [5:0] s,
                                              input logic [9:0] tot, input logic [14:0] rl,
                                              input logic [15:0] fv, input logic [15:0] tv);
    slot_view_t v;
    int         req;
    v = '0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (anim_playing[i]) begin
            if ($signed(anim_timer[i]) < 16'sd2) begin
              if (bump_anim_frame(i) && anim_once[i]) begin
                anim_once[i]    = 1'b0;
                anim_playing[i] = 1'b0;
                if (v.stopped < 7'd127) begin
                  v.stopped = v.stopped + 7'd1;
                end
              end
              anim_timer[i] = {1'b0, anim_reload[i]};
            end else begin
              anim_timer[i] = anim_timer[i] - 16'd2;
            end
          end
        end
      end
      OP_LOAD: begin
        anim_frame[s]  = fv;
        anim_total[s]  = tot;
        anim_timer[s]  = tv;
        anim_reload[s] = rl;
      end
      OP_PLAY, OP_ONCE: begin
        if (anim_total[s] > 10'd1) begin
          anim_playing[s] = 1'b1;
        end
        if (op == OP_ONCE) begin
          anim_once[s] = 1'b1;
        end
      end
      OP_STOP: begin
        if (anim_playing[s]) begin
          anim_playing[s] = 1'b0;
          v.removed       = 1'b1;
        end
      end
      OP_SETFRM: begin
        req = $signed(fv);
        if (req < 0) begin
          req = 0;
        end
        if (req >= int'(anim_total[s])) begin
          req = int'(anim_total[s]) - 1;
        end
        anim_frame[s] = req[15:0];
      end
      OP_ADV: begin
        void'(bump_anim_frame(s));
      end
      default: begin
      end
    endcase
    v.frame   = anim_frame[s];
    v.playing = anim_playing[s];
    v.once    = anim_once[s];
    return v;
  endfunction

  function automatic drill_row_t mk_row(input logic [2:0] op, input int s, input int tot,
                                        input int rl, input int fv, input int tv,
                                        input bit fixed_on, input int ef, input bit ep,
                                        input bit eo, input bit er, input int es);
    drill_row_t r;
    r.op             = op;
    r.slot           = s[5:0];
    r.total          = tot[9:0];
    r.reload         = rl[14:0];
    r.fval           = fv[15:0];
    r.tval           = tv[15:0];
    r.fixed_on       = fixed_on;
    r.fixed.frame    = ef[15:0];
    r.fixed.playing  = ep;
    r.fixed.once     = eo;
    r.fixed.removed  = er;
    r.fixed.stopped  = es[6:0];
    return r;
  endfunction

  // Mostly small values, with extremes and full-range values mixed in
  function automatic logic [15:0] pick_s16(input int lo, input int hi);
    int r;
    int v;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      v = -32768;
    end else if (r == 1) begin
      v = 32767;
    end else if (r == 2) begin
      v = -1;
    end else if (r < 7) begin
      v = $urandom_range(0, 65535);
    end else begin
      v = lo + $urandom_range(0, hi - lo);
    end
    return v[15:0];
  endfunction

  // Present one word, hold it until accepted, then log its expected view
  task automatic put_word(input logic [2:0] op, input logic [5:0] s, input logic [9:0] tot,
                          input logic [14:0] rl, input logic [15:0] fv, input logic [15:0] tv,
                          input bit fixed_on, input slot_view_t fixed);
    slot_view_t v;
    opcode       = op;
    slot         = s;
    frame_total  = tot;
    reload_delay = rl;
    frame_value  = fv;
    timer_value  = tv;
    in_valid     = 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    v = predict_view(op, s, tot, rl, fv, tv);
    view_q.push_back(fixed_on ? fixed : v);
    op_seen[op]++;
    self_stops += v.stopped;
    removals   += v.removed;
    @(negedge clk);
  endtask

  // Receiver: stall on a pattern whose mode is redrawn each time its countdown runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left = stall_left - 1;
    end
    stall_tick = stall_tick + 1;
    case (stall_mode)
      0: out_ready = 1'b1;
      1: out_ready = $urandom_range(0, 1);
      2: out_ready = ($urandom_range(0, 7) == 0);
      default: out_ready = ((stall_tick % 5) < 2);
    endcase
  end

  // Check each output word against the oldest expected view
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (view_q.size() == 0) begin
        $error("output word with no expected view: frame %0d", frame);
        fails++;
      end else begin
        want = view_q.pop_front();
        if (frame !== want.frame) begin
          $error("frame expected %0d got %0d", want.frame, frame);
          fails++;
        end
        if (playing !== want.playing) begin
          $error("playing expected %0d got %0d", want.playing, playing);
          fails++;
        end
        if (play_once !== want.once) begin
          $error("play_once expected %0d got %0d", want.once, play_once);
          fails++;
        end
        if (removed !== want.removed) begin
          $error("removed expected %0d got %0d", want.removed, removed);
          fails++;
        end
        if (stopped_count !== want.stopped) begin
          $error("stopped_count expected %0d got %0d", want.stopped, stopped_count);
          fails++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    drill_row_t  row;
    slot_view_t  none;
    logic [2:0]  op;
    logic [5:0]  s;
    logic [9:0]  tot;
    logic [14:0] rl;
    logic [15:0] fv;
    logic [15:0] tv;
    int          pick;
    int          burst;
    int          gap;

    rst          = 1'b1;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    opcode       = OP_READ;
    slot         = '0;
    frame_total  = '0;
    reload_delay = '0;
    frame_value  = '0;
    timer_value  = '0;
    fails        = 0;
    self_stops   = 0;
    removals     = 0;
    idle_cycles  = 0;
    stall_mode   = 0;
    stall_left   = 0;
    stall_tick   = 0;
    none         = '0;
    for (int i = 0; i < 8; i++) begin
      op_seen[i] = 0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      anim_playing[i] = 1'b0;
      anim_once[i]    = 1'b0;
      anim_frame[i]   = '0;
      anim_total[i]   = '0;
      anim_timer[i]   = '0;
      anim_reload[i]  = '0;
    end

    // Directed table: fixed views where they follow directly, else the predictor
    drill_q.push_back(mk_row(OP_READ,    0,    0,     0,      0,      0, 1,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_PLAY,    5,    0,     0,      0,      0, 1,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_ONCE,    5,    0,     0,      0,      0, 1,     0, 0, 1, 0, 0));
    drill_q.push_back(mk_row(OP_SETFRM,  5,    0,     0,    100,      0, 1,    -1, 0, 1, 0, 0));
    drill_q.push_back(mk_row(OP_STOP,    5,    0,     0,      0,      0, 1,    -1, 0, 1, 0, 0));
    drill_q.push_back(mk_row(OP_LOAD,   63, 1023, 32767,  32767, -32768, 1, 32767, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_ADV,    63,    0,     0,      0,      0, 1,-32768, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_SETFRM, 63,    0,     0, -32768,      0, 1,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_SETFRM, 63,    0,     0,  32767,      0, 1,  1022, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_PLAY,   63,    0,     0,      0,      0, 1,  1022, 1, 0, 0, 0));
    drill_q.push_back(mk_row(OP_TICK,   63,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_TICK,   63,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_LOAD,    1,    2,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_ONCE,    1,    0,     0,      0,      0, 1,     0, 1, 1, 0, 0));
    drill_q.push_back(mk_row(OP_TICK,    1,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_TICK,    1,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_STOP,   63,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_STOP,   63,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_LOAD,    0,    0,     0, -32768,  32767, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_ADV,     0,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_LOAD,    2,    1,     5,      0,      1, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_PLAY,    2,    0,     0,      0,      0, 1,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_LOAD,    3,    3,     1,      2,      2, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_ONCE,    3,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));
    drill_q.push_back(mk_row(OP_TICK,    3,    0,     0,      0,      0, 0,     0, 0, 0, 0, 0));

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table back to back
    foreach (drill_q[i]) begin
      row = drill_q[i];
      put_word(row.op, row.slot, row.total, row.reload, row.fval, row.tval,
               row.fixed_on, row.fixed);
    end

    // Random words in bursts with gaps; unused fields carry noise
    burst = 0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      end
      burst = burst - 1;

      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        op = OP_LOAD;
      end else if (pick < 28) begin
        op = OP_PLAY;
      end else if (pick < 35) begin
        op = OP_ONCE;
      end else if (pick < 43) begin
        op = OP_STOP;
      end else if (pick < 51) begin
        op = OP_SETFRM;
      end else if (pick < 61) begin
        op = OP_ADV;
      end else if (pick < 86) begin
        op = OP_TICK;
      end else begin
        op = OP_READ;
      end

      // Keep most traffic on a few slots so loads, plays and ticks meet
      s  = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
      tot = 10'($urandom_range(0, 1023));
      rl  = 15'($urandom_range(0, 32767));
      fv  = 16'($urandom_range(0, 65535));
      tv  = 16'($urandom_range(0, 65535));
      if (op == OP_LOAD) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          tot = 10'($urandom_range(0, 6));
        end else if (pick < 17) begin
          tot = 10'($urandom_range(0, 20));
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          rl = 15'($urandom_range(0, 6));
        end else if (pick < 8) begin
          rl = 15'($urandom_range(0, 40));
        end
        fv = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, int'(tot))) : pick_s16(0, 8);
        tv = pick_s16(-3, 8);
      end else if (op == OP_SETFRM) begin
        fv = pick_s16(-2, 10);
      end
      put_word(op, s, tot, rl, fv, tv, 1'b0, none);
    end
    in_valid = 1'b0;

    // Drain, then give a stray word time to show up
    while (view_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered: load %0d, play %0d, once %0d, stop %0d, set %0d, adv %0d, tick %0d, read %0d",
             op_seen[OP_LOAD], op_seen[OP_PLAY], op_seen[OP_ONCE], op_seen[OP_STOP],
             op_seen[OP_SETFRM], op_seen[OP_ADV], op_seen[OP_TICK], op_seen[OP_READ]);
    $display("covered: %0d self-stops on wrap, %0d stops that removed a playing slot",
             self_stops, removals);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
